FILE: hw/rtl/svdc_pkg.sv
// Shared types, codes and helper functions for the servo datagram checker.
package svdc_pkg;

    localparam int RESET_LEN = 6;
    localparam int POS_FIRST = 14;
    localparam logic [5:0] BYTE_POS_MAX = 6'h3F;

    localparam int MAX_CHANNELS = 6;
    localparam int ANGLE_W = 40;
    localparam int ANGLE_SHIFT = 11;
    localparam logic signed [18:0] ANGLE_MUL = 19'sd205887;

    // Configuration register indexes
    localparam logic [1:0] REG_DATA_MAGIC    = 2'd0;
    localparam logic [1:0] REG_RESET_MAGIC   = 2'd1;
    localparam logic [1:0] REG_CENTER_OFFSET = 2'd2;

    localparam logic [15:0] DATA_MAGIC_RST    = 16'hAA55;
    localparam logic [15:0] RESET_MAGIC_RST   = 16'hAA56;
    localparam logic [15:0] CENTER_OFFSET_RST = 16'd2048;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0] VERDICT_RESET     = 3'd1;
    localparam logic [2:0] VERDICT_BAD_LEN   = 3'd2;
    localparam logic [2:0] VERDICT_BAD_DATA  = 3'd3;
    localparam logic [2:0] VERDICT_BAD_RESET = 3'd4;
    localparam logic [2:0] VERDICT_STALE     = 3'd5;

    // Datagram kind by length
    localparam logic [1:0] KIND_BAD_LEN = 2'd0;
    localparam logic [1:0] KIND_RESET   = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        hdr_data_ok;
        logic        hdr_reset_ok;
        logic [31:0] seq;
    } frame_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // ((pos - center) * 205887) >>> 11, floor shift
    function automatic logic [ANGLE_W-1:0] angle_of(input logic [31:0] pos,
                                                    input logic [15:0] center);
        logic signed [32:0] diff;
        logic signed [51:0] prod;
        diff = $signed({pos[31], pos}) - $signed({17'b0, center});
        prod = diff * ANGLE_MUL;
        return prod[ANGLE_SHIFT +: ANGLE_W];
    endfunction

endpackage

FILE: hw/rtl/svdc_parse.sv
// Byte assembly of header, sequence and positions; registers one frame per final byte.
module svdc_parse #(
    parameter int CHANNELS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [7:0]           rx_byte,
    input  logic                 rx_last,
    input  logic [15:0]          data_magic,
    input  logic [15:0]          reset_magic,
    input  logic                 frame_take,
    output logic                 frame_vld,
    output svdc_pkg::frame_t     frame,
    output logic [31:0]          frame_pos [CHANNELS]
);

    localparam int DATA_LEN = svdc_pkg::POS_FIRST + 4 * CHANNELS;

    logic [5:0]  byte_pos_reg, byte_pos_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] pos_reg  [CHANNELS];
    logic [31:0] pos_next [CHANNELS];
    logic        frame_vld_reg;
    svdc_pkg::frame_t frame_reg, frame_next;
    logic [31:0] frame_pos_reg [CHANNELS];

    logic [5:0]  rel;
    logic        in_pos_range;

    assign rel          = byte_pos_reg - 6'(svdc_pkg::POS_FIRST);
    assign in_pos_range = (byte_pos_reg >= 6'(svdc_pkg::POS_FIRST)) &&
                          (byte_pos_reg < 6'(DATA_LEN));

    always_comb begin
        hdr_next = hdr_reg;
        seq_next = seq_reg;
        if (byte_pos_reg == 6'd0) begin
            hdr_next[7:0] = rx_byte;
        end else if (byte_pos_reg == 6'd1) begin
            hdr_next[15:8] = rx_byte;
        end else if (byte_pos_reg == 6'd2) begin
            seq_next[7:0] = rx_byte;
        end else if (byte_pos_reg == 6'd3) begin
            seq_next[15:8] = rx_byte;
        end else if (byte_pos_reg == 6'd4) begin
            seq_next[23:16] = rx_byte;
        end else if (byte_pos_reg == 6'd5) begin
            seq_next[31:24] = rx_byte;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            pos_next[ch] = pos_reg[ch];
            if (in_pos_range && (rel[5:2] == 4'(ch))) begin
                case (rel[1:0])
                    2'd0: pos_next[ch][7:0]   = rx_byte;
                    2'd1: pos_next[ch][15:8]  = rx_byte;
                    2'd2: pos_next[ch][23:16] = rx_byte;
                    default: pos_next[ch][31:24] = rx_byte;
                endcase
            end
        end
    end

    always_comb begin
        if (rx_last) begin
            byte_pos_next = 6'd0;
        end else if (byte_pos_reg == svdc_pkg::BYTE_POS_MAX) begin
            byte_pos_next = byte_pos_reg;
        end else begin
            byte_pos_next = byte_pos_reg + 6'd1;
        end
    end

    always_comb begin
        if (byte_pos_reg == 6'(svdc_pkg::RESET_LEN - 1)) begin
            frame_next.kind = svdc_pkg::KIND_RESET;
        end else if (byte_pos_reg == 6'(DATA_LEN - 1)) begin
            frame_next.kind = svdc_pkg::KIND_DATA;
        end else begin
            frame_next.kind = svdc_pkg::KIND_BAD_LEN;
        end
        frame_next.hdr_data_ok  = (hdr_next == data_magic);
        frame_next.hdr_reset_ok = (hdr_next == reset_magic);
        frame_next.seq          = seq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= '0;
            hdr_reg      <= '0;
            seq_reg      <= '0;
        end else if (in_fire) begin
            byte_pos_reg <= byte_pos_next;
            hdr_reg      <= rx_last ? 16'd0 : hdr_next;
            seq_reg      <= rx_last ? 32'd0 : seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_vld_reg <= 1'b0;
        end else if (in_fire && rx_last) begin
            frame_vld_reg <= 1'b1;
        end else if (frame_take) begin
            frame_vld_reg <= 1'b0;
        end
    end

    // Position store and frame payload carry no reset
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pos_reg <= pos_next;
        end
        if (in_fire && rx_last) begin
            frame_reg     <= frame_next;
            frame_pos_reg <= pos_next;
        end
    end

    assign frame_vld = frame_vld_reg;
    assign frame     = frame_reg;
    assign frame_pos = frame_pos_reg;

endmodule

FILE: hw/rtl/svdc_judge.sv
// Verdict, sequence tracking, saturating counters and angle conversion into the result register.
module svdc_judge #(
    parameter int CHANNELS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 frame_vld,
    input  svdc_pkg::frame_t     frame,
    input  logic [31:0]          frame_pos [CHANNELS],
    input  logic [15:0]          center_offset,
    input  logic                 m_ready,
    output logic                 frame_take,
    output logic                 m_vld,
    output logic [2:0]           verdict,
    output logic [31:0]          frame_sequence,
    output logic [svdc_pkg::ANGLE_W-1:0] angle [svdc_pkg::MAX_CHANNELS],
    output logic [31:0]          accepted_total,
    output logic [31:0]          error_total,
    output logic [31:0]          stale_total
);

    logic        m_vld_reg;
    logic [2:0]  verdict_reg, verdict_next;
    logic [31:0] seq_out_reg, seq_out_next;
    logic        tracking_reg, tracking_next;
    logic [31:0] last_acc_reg, last_acc_next;
    logic [31:0] acc_cnt_reg, acc_cnt_next;
    logic [31:0] err_cnt_reg, err_cnt_next;
    logic [31:0] stale_cnt_reg, stale_cnt_next;
    logic [svdc_pkg::ANGLE_W-1:0] angle_reg [CHANNELS];

    assign frame_take = frame_vld && (!m_vld_reg || m_ready);

    always_comb begin
        verdict_next   = svdc_pkg::VERDICT_BAD_LEN;
        seq_out_next   = frame.seq;
        tracking_next  = tracking_reg;
        last_acc_next  = last_acc_reg;
        acc_cnt_next   = acc_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        stale_cnt_next = stale_cnt_reg;
        unique case (frame.kind)
            svdc_pkg::KIND_RESET: begin
                if (frame.hdr_reset_ok) begin
                    verdict_next   = svdc_pkg::VERDICT_RESET;
                    tracking_next  = 1'b0;
                    last_acc_next  = '0;
                    stale_cnt_next = '0;
                end else begin
                    verdict_next = svdc_pkg::VERDICT_BAD_RESET;
                    err_cnt_next = svdc_pkg::sat_inc(err_cnt_reg);
                end
            end
            svdc_pkg::KIND_DATA: begin
                if (!frame.hdr_data_ok) begin
                    verdict_next = svdc_pkg::VERDICT_BAD_DATA;
                    err_cnt_next = svdc_pkg::sat_inc(err_cnt_reg);
                end else if (tracking_reg && (frame.seq <= last_acc_reg)) begin
                    verdict_next   = svdc_pkg::VERDICT_STALE;
                    stale_cnt_next = svdc_pkg::sat_inc(stale_cnt_reg);
                end else begin
                    verdict_next  = svdc_pkg::VERDICT_ACCEPT;
                    tracking_next = 1'b1;
                    last_acc_next = frame.seq;
                    acc_cnt_next  = svdc_pkg::sat_inc(acc_cnt_reg);
                end
            end
            default: begin
                verdict_next = svdc_pkg::VERDICT_BAD_LEN;
                seq_out_next = '0;
                err_cnt_next = svdc_pkg::sat_inc(err_cnt_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg     <= 1'b0;
            tracking_reg  <= 1'b0;
            last_acc_reg  <= '0;
            acc_cnt_reg   <= '0;
            err_cnt_reg   <= '0;
            stale_cnt_reg <= '0;
        end else begin
            if (frame_take) begin
                m_vld_reg     <= 1'b1;
                tracking_reg  <= tracking_next;
                last_acc_reg  <= last_acc_next;
                acc_cnt_reg   <= acc_cnt_next;
                err_cnt_reg   <= err_cnt_next;
                stale_cnt_reg <= stale_cnt_next;
            end else if (m_ready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_take) begin
            verdict_reg <= verdict_next;
            seq_out_reg <= seq_out_next;
        end
    end

    // One multiplier per channel, straight into the result register
    for (genvar i = 0; i < svdc_pkg::MAX_CHANNELS; i++) begin : g_angle
        if (i < CHANNELS) begin : g_live
            always_ff @(posedge aclk) begin
                if (frame_take) begin
                    angle_reg[i] <= (verdict_next == svdc_pkg::VERDICT_ACCEPT) ?
                        svdc_pkg::angle_of(frame_pos[i], center_offset) : '0;
                end
            end
            assign angle[i] = angle_reg[i];
        end else begin : g_unused
            assign angle[i] = '0;
        end
    end

    assign m_vld          = m_vld_reg;
    assign verdict        = verdict_reg;
    assign frame_sequence = seq_out_reg;
    assign accepted_total = acc_cnt_reg;
    assign error_total    = err_cnt_reg;
    assign stale_total    = stale_cnt_reg;

endmodule

FILE: hw/rtl/servo_datagram_checker.sv
// Top level of the servo datagram checker: ports, configuration registers, result packing.
// Takes one payload byte per cycle with tlast on the final byte of each datagram and returns
// one result per datagram, passed from the byte assembly register to the verdict/angle
// register, which holds one 33x19 multiply per channel. The byte stream keeps flowing while
// a result waits; it stalls only when both the frame register and the result register are
// full and the sink is not ready. A 6-byte datagram is a reset frame, a 14 + 4*CHANNELS
// byte datagram is a data frame; angles are ((position - center_offset) * 205887) >>> 11
// in Q16 radians and read zero unless the verdict is data accepted. Configuration writes
// are meant for idle periods only.
module servo_datagram_checker #(
    parameter int CHANNELS = 6
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic         s_axis_tlast,   // end_of_datagram

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] verdict, [34:3] frame_sequence, [74:35] angle_one, [114:75] angle_two,
    // [154:115] angle_three, [194:155] angle_four, [234:195] angle_five,
    // [274:235] angle_six, [306:275] accepted_total, [338:307] error_total,
    // [370:339] stale_total, [375:371] zero
    output logic [375:0] m_axis_tdata
);

    logic [15:0] data_magic_reg;
    logic [15:0] reset_magic_reg;
    logic [15:0] center_offset_reg;

    logic             in_fire;
    logic             frame_vld;
    logic             frame_take;
    svdc_pkg::frame_t frame;
    logic [31:0]      frame_pos [CHANNELS];

    logic [2:0]  verdict;
    logic [31:0] frame_sequence;
    logic [svdc_pkg::ANGLE_W-1:0] angle [svdc_pkg::MAX_CHANNELS];
    logic [31:0] accepted_total;
    logic [31:0] error_total;
    logic [31:0] stale_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_magic_reg    <= svdc_pkg::DATA_MAGIC_RST;
            reset_magic_reg   <= svdc_pkg::RESET_MAGIC_RST;
            center_offset_reg <= svdc_pkg::CENTER_OFFSET_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                svdc_pkg::REG_DATA_MAGIC:    data_magic_reg    <= cfg_wdata;
                svdc_pkg::REG_RESET_MAGIC:   reset_magic_reg   <= cfg_wdata;
                svdc_pkg::REG_CENTER_OFFSET: center_offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !frame_vld || frame_take;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    svdc_parse #(
        .CHANNELS (CHANNELS)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .rx_byte     (s_axis_tdata),
        .rx_last     (s_axis_tlast),
        .data_magic  (data_magic_reg),
        .reset_magic (reset_magic_reg),
        .frame_take  (frame_take),
        .frame_vld   (frame_vld),
        .frame       (frame),
        .frame_pos   (frame_pos)
    );

    svdc_judge #(
        .CHANNELS (CHANNELS)
    ) u_judge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .frame_vld      (frame_vld),
        .frame          (frame),
        .frame_pos      (frame_pos),
        .center_offset  (center_offset_reg),
        .m_ready        (m_axis_tready),
        .frame_take     (frame_take),
        .m_vld          (m_axis_tvalid),
        .verdict        (verdict),
        .frame_sequence (frame_sequence),
        .angle          (angle),
        .accepted_total (accepted_total),
        .error_total    (error_total),
        .stale_total    (stale_total)
    );

    assign m_axis_tdata = {5'b0, stale_total, error_total, accepted_total,
                           angle[5], angle[4], angle[3], angle[2], angle[1], angle[0],
                           frame_sequence, verdict};

    // Input only stalls when both pipeline registers are full and the sink is stalling
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_angles_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (verdict != svdc_pkg::VERDICT_ACCEPT)) |->
        (m_axis_tdata[274:35] == '0))
        else $error("angle nonzero on a request that was not accepted");

    a_badlen_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (verdict == svdc_pkg::VERDICT_BAD_LEN)) |->
        (frame_sequence == '0))
        else $error("sequence reported for a bad length datagram");

    a_reset_clears_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (verdict == svdc_pkg::VERDICT_RESET)) |-> (stale_total == '0))
        else $error("stale count not cleared by a reset frame");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (verdict <= svdc_pkg::VERDICT_STALE))
        else $error("verdict code out of range");

endmodule

FILE: tb/sv/tb_servo_datagram_checker.sv
// Self-checking testbench for servo_datagram_checker: directed and random datagrams.
`timescale 1ns / 1ps

module tb_servo_datagram_checker;

    localparam int FRAME_LEN      = svdc_pkg::POS_FIRST + 4 * svdc_pkg::MAX_CHANNELS;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRINT_LIMIT    = 40;

    // Packed to match m_axis_tdata, highest bits first.
    typedef struct packed {
        logic [4:0]                                                    pad;
        logic [31:0]                                                   stale_total;
        logic [31:0]                                                   error_total;
        logic [31:0]                                                   accepted_total;
        logic [svdc_pkg::MAX_CHANNELS-1:0][svdc_pkg::ANGLE_W-1:0]      angles;
        logic [31:0]                                                   frame_sequence;
        logic [2:0]                                                    verdict;
    } datagram_result_t;

    class datagram_scoreboard;
        logic [15:0] data_magic_q;
        logic [15:0] reset_magic_q;
        logic [15:0] center_q;
        logic [5:0]  byte_pos;
        logic [15:0] header;
        logic [31:0] seq_word;
        logic [31:0] positions [svdc_pkg::MAX_CHANNELS];
        bit          tracking;
        logic [31:0] last_seq;
        logic [31:0] n_accepted;
        logic [31:0] n_errors;
        logic [31:0] n_stale;
        datagram_result_t verdicts_due [$];
        int mismatches;
        int checked;
        int verdict_tally [6];

        function new();
            data_magic_q  = svdc_pkg::DATA_MAGIC_RST;
            reset_magic_q = svdc_pkg::RESET_MAGIC_RST;
            center_q      = svdc_pkg::CENTER_OFFSET_RST;
            byte_pos   = '0;
            header     = '0;
            seq_word   = '0;
            tracking   = 1'b0;
            last_seq   = '0;
            n_accepted = '0;
            n_errors   = '0;
            n_stale    = '0;
            mismatches = 0;
            checked    = 0;
            foreach (positions[i]) positions[i] = '0;
            foreach (verdict_tally[i]) verdict_tally[i] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                svdc_pkg::REG_DATA_MAGIC:    data_magic_q  = value;
                svdc_pkg::REG_RESET_MAGIC:   reset_magic_q = value;
                svdc_pkg::REG_CENTER_OFFSET: center_q      = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] bump(logic [31:0] c);
            return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
        endfunction

        // floor((raw - center) * 205887 / 2048), low 40 bits
        function logic [svdc_pkg::ANGLE_W-1:0] rad_q16(logic [31:0] raw);
            longint offs;
            longint scaled;
            offs   = longint'($signed(raw)) - longint'({48'b0, center_q});
            scaled = (offs * longint'(svdc_pkg::ANGLE_MUL)) >>> svdc_pkg::ANGLE_SHIFT;
            return scaled[svdc_pkg::ANGLE_W-1:0];
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void enqueue_due(datagram_result_t r);
            verdicts_due.insert(verdicts_due.size(), r);
        endfunction

        function void note_request(logic [7:0] value, logic is_last);
            int p;
            int off;
            datagram_result_t r;
            p = int'(byte_pos);
            if (p == 0)
                header[7:0] = value;
            else if (p == 1)
                header[15:8] = value;
            else if (p >= 2 && p <= 5)
                seq_word[8*(p-2) +: 8] = value;
            else if (p >= svdc_pkg::POS_FIRST && p < FRAME_LEN) begin
                off = p - svdc_pkg::POS_FIRST;
                positions[off/4][8*(off%4) +: 8] = value;
            end

            if (!is_last) begin
                if (byte_pos != svdc_pkg::BYTE_POS_MAX) byte_pos = byte_pos + 6'd1;
                return;
            end

            r = '0;
            if (p + 1 == svdc_pkg::RESET_LEN) begin
                r.frame_sequence = seq_word;
                if (header == reset_magic_q) begin
                    tracking = 1'b0;
                    last_seq = '0;
                    n_stale  = '0;
                    r.verdict = svdc_pkg::VERDICT_RESET;
                end else begin
                    n_errors  = bump(n_errors);
                    r.verdict = svdc_pkg::VERDICT_BAD_RESET;
                end
            end else if (p + 1 == FRAME_LEN) begin
                r.frame_sequence = seq_word;
                if (header != data_magic_q) begin
                    n_errors  = bump(n_errors);
                    r.verdict = svdc_pkg::VERDICT_BAD_DATA;
                end else if (tracking && seq_word <= last_seq) begin
                    n_stale   = bump(n_stale);
                    r.verdict = svdc_pkg::VERDICT_STALE;
                end else begin
                    tracking   = 1'b1;
                    last_seq   = seq_word;
                    n_accepted = bump(n_accepted);
                    r.verdict  = svdc_pkg::VERDICT_ACCEPT;
                    for (int ch = 0; ch < svdc_pkg::MAX_CHANNELS; ch++)
                        r.angles[ch] = rad_q16(positions[ch]);
                end
            end else begin
                n_errors  = bump(n_errors);
                r.verdict = svdc_pkg::VERDICT_BAD_LEN;
            end
            r.accepted_total = n_accepted;
            r.error_total    = n_errors;
            r.stale_total    = n_stale;
            verdict_tally[int'(r.verdict)]++;
            enqueue_due(r);
            byte_pos = '0;
            header   = '0;
            seq_word = '0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        endtask

        task check_result(logic [375:0] data);
            datagram_result_t got;
            datagram_result_t want;
            got = data;
            checked++;
            if (verdicts_due.size() == 0) begin
                report("result with no datagram outstanding", 64'(got.verdict), 64'(0));
                return;
            end
            want = verdicts_due.pop_front();
            if (got.verdict !== want.verdict)
                report("verdict", 64'(got.verdict), 64'(want.verdict));
            if (got.frame_sequence !== want.frame_sequence)
                report("frame_sequence", 64'(got.frame_sequence), 64'(want.frame_sequence));
            for (int ch = 0; ch < svdc_pkg::MAX_CHANNELS; ch++)
                if (got.angles[ch] !== want.angles[ch])
                    report($sformatf("angle ch%0d", ch + 1), 64'(got.angles[ch]),
                           64'(want.angles[ch]));
            if (got.accepted_total !== want.accepted_total)
                report("accepted_total", 64'(got.accepted_total), 64'(want.accepted_total));
            if (got.error_total !== want.error_total)
                report("error_total", 64'(got.error_total), 64'(want.error_total));
            if (got.stale_total !== want.stale_total)
                report("stale_total", 64'(got.stale_total), 64'(want.stale_total));
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [375:0] m_axis_tdata;

    datagram_scoreboard sb;
    logic [7:0]  frame_bytes [$];
    logic [31:0] chan_pos [svdc_pkg::MAX_CHANNELS];
    int bytes_sent = 0;
    int datagrams_sent = 0;
    int results_seen = 0;
    int hold_left = 0;
    int stall_left = 0;
    bit sink_calm = 1'b0;

    servo_datagram_checker u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_position();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return {16'h0, sb.center_q};
            5: return {16'h0, sb.center_q} + $urandom_range(0, 8) - 4;
            6: return $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    function automatic void fill_positions();
        foreach (chan_pos[ch]) chan_pos[ch] = pick_position();
    endfunction

    function automatic void add_byte(logic [7:0] value);
        frame_bytes.insert(frame_bytes.size(), value);
    endfunction

    function automatic void load_data_frame(logic [15:0] magic, logic [31:0] seq);
        frame_bytes = {};
        add_byte(magic[7:0]);
        add_byte(magic[15:8]);
        for (int i = 0; i < 4; i++) add_byte(seq[8*i +: 8]);
        for (int i = 6; i < svdc_pkg::POS_FIRST; i++) add_byte(8'($urandom));
        for (int ch = 0; ch < svdc_pkg::MAX_CHANNELS; ch++)
            for (int i = 0; i < 4; i++) add_byte(chan_pos[ch][8*i +: 8]);
    endfunction

    function automatic void load_reset_frame(logic [15:0] magic, logic [31:0] seq);
        frame_bytes = {};
        add_byte(magic[7:0]);
        add_byte(magic[15:8]);
        for (int i = 0; i < 4; i++) add_byte(seq[8*i +: 8]);
    endfunction

    function automatic void load_noise(int len);
        frame_bytes = {};
        for (int i = 0; i < len; i++) add_byte(8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic is_last, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_request(value, is_last);
        bytes_sent++;
    endtask

    task automatic send_datagram();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, calm);
        datagrams_sent++;
    endtask

    task automatic send_random_datagram();
        int r;
        int s;
        logic [31:0] seq;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            s = $urandom_range(0, 19);
            if (s < 14)
                seq = sb.last_seq + $urandom_range(1, 6);
            else if (s < 16)
                seq = sb.last_seq;
            else if (s < 18)
                seq = sb.last_seq - $urandom_range(1, 6);
            else
                seq = $urandom;
            fill_positions();
            load_data_frame(sb.data_magic_q, seq);
        end else if (r < 65) begin
            fill_positions();
            load_data_frame(sb.data_magic_q ^ 16'($urandom_range(1, 65535)), $urandom);
        end else if (r < 77) begin
            load_reset_frame(sb.reset_magic_q, $urandom);
        end else if (r < 82) begin
            load_reset_frame(sb.reset_magic_q ^ 16'($urandom_range(1, 65535)), $urandom);
        end else begin
            s = $urandom_range(0, 99);
            if (s < 30)
                load_noise($urandom_range(1, svdc_pkg::RESET_LEN - 1));
            else if (s < 60)
                load_noise($urandom_range(svdc_pkg::RESET_LEN + 1, FRAME_LEN - 1));
            else if (s < 85)
                load_noise($urandom_range(FRAME_LEN + 1, 63));
            else
                load_noise($urandom_range(64, 90));
        end
        send_datagram();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_one(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    task automatic write_regs(input logic [15:0] dmagic, input logic [15:0] rmagic,
                              input logic [15:0] center);
        write_one(svdc_pkg::REG_DATA_MAGIC, dmagic);
        write_one(svdc_pkg::REG_RESET_MAGIC, rmagic);
        write_one(svdc_pkg::REG_CENTER_OFFSET, center);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: checks, random stalls, and two long hold-offs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                results_seen++;
                if (results_seen == 21 || results_seen == 34) hold_left = HOLD_CYCLES;
                if (results_seen % 20 == 0) sink_calm = ($urandom_range(0, 2) == 0);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!sink_calm && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int bad_lens [9];
        int phase_bytes;
        int phase_frames;
        bad_lens = '{1, 2, 5, 7, 37, 39, 63, 64, 70};
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset register values
        chan_pos = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'd2048, 32'd2047};
        load_data_frame(svdc_pkg::DATA_MAGIC_RST, 32'd0);
        send_datagram();                        // tracking clear, sequence 0 accepted
        send_datagram();                        // same sequence again: stale
        fill_positions();
        load_data_frame(svdc_pkg::DATA_MAGIC_RST, 32'd5);
        send_datagram();
        load_data_frame(svdc_pkg::DATA_MAGIC_RST, 32'd3);
        send_datagram();                        // lower sequence: stale
        load_data_frame(~svdc_pkg::DATA_MAGIC_RST, 32'd9);
        send_datagram();
        load_reset_frame(svdc_pkg::RESET_MAGIC_RST, 32'h1234_5678);
        send_datagram();
        fill_positions();
        load_data_frame(svdc_pkg::DATA_MAGIC_RST, 32'd1);
        send_datagram();                        // accepted again after reset frame
        load_reset_frame(~svdc_pkg::RESET_MAGIC_RST, $urandom);
        send_datagram();
        foreach (bad_lens[i]) begin
            load_noise(bad_lens[i]);
            send_datagram();
        end
        fill_positions();
        load_data_frame(svdc_pkg::DATA_MAGIC_RST, 32'hFFFF_FFFF);
        send_datagram();
        fill_positions();
        load_data_frame(svdc_pkg::DATA_MAGIC_RST, 32'h0000_0000);
        send_datagram();                        // no wrap: stale after the top sequence
        drain();

        for (int phase = 1; phase <= 3; phase++) begin
            case (phase)
                1: write_regs(16'h0000, 16'hFFFF, 16'h0000);
                2: write_regs(16'hFFFF, 16'h0000, 16'hFFFF);
                default: write_regs(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            phase_bytes  = bytes_sent + 160;
            phase_frames = datagrams_sent + 6;
            while (bytes_sent < phase_bytes || datagrams_sent < phase_frames)
                send_random_datagram();
            drain();
        end

        $display("Sent %0d datagrams (%0d bytes) under four register settings,",
                 datagrams_sent, bytes_sent);
        $display("  %0d results checked; accept %0d, reset %0d, bad length %0d,",
                 sb.checked, sb.verdict_tally[svdc_pkg::VERDICT_ACCEPT],
                 sb.verdict_tally[svdc_pkg::VERDICT_RESET],
                 sb.verdict_tally[svdc_pkg::VERDICT_BAD_LEN]);
        $display("  bad data magic %0d, bad reset magic %0d, stale %0d",
                 sb.verdict_tally[svdc_pkg::VERDICT_BAD_DATA],
                 sb.verdict_tally[svdc_pkg::VERDICT_BAD_RESET],
                 sb.verdict_tally[svdc_pkg::VERDICT_STALE]);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
